[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/dfs_pkg.sv]
// Shared types and constants of the directional focus select block.
package dfs_pkg;

   localparam int DFS_MAX_TARGETS = 64;
   localparam int DFS_COORD_BITS  = 16;

   localparam int ENTRY_BITS  = 6;
   localparam int COUNT_BITS  = 7;
   localparam int DIR_BITS    = 2;
   localparam int CHOSEN_BITS = 7;

   // Across offset weighs eight times the along offset.
   localparam int ACROSS_SHIFT = 3;

   localparam logic [CHOSEN_BITS-1:0] INVALID_INDEX = '1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_LOCATE,
      STATE_SCORE,
      STATE_FINISH
   } state_type;

   typedef struct packed {
      logic accept_load;
      logic accept_query;
      logic issue;
      logic score_mode;
      logic start_score;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic trivial;
      logic all_issued;
      logic pipe_busy;
      logic hit_found;
   } ctrl_status_type;

endpackage

[hw/rtl/dfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/dfs_controller.sv]
// Sequencer of the directional focus select block: handshakes and walk control.
module dfs_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_action,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  dfs_pkg::ctrl_status_type  status,
   output dfs_pkg::ctrl_cmd_type     cmd
);
   import dfs_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      locate_done;
   logic      rsp_free;

   // Locate ends on a trivial query, or once the walk stopped and the pipe drained.
   assign locate_done = status.trivial
                        || ((status.all_issued || status.hit_found) && !status.pipe_busy);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid && req_action == ACT_QUERY) begin
               state_in = STATE_LOCATE;
            end
         end
         STATE_LOCATE: begin
            if (locate_done) begin
               state_in = (!status.trivial && status.hit_found) ? STATE_SCORE : STATE_FINISH;
            end
         end
         STATE_SCORE: begin
            if (status.all_issued && !status.pipe_busy) begin
               state_in = STATE_FINISH;
            end
         end
         STATE_FINISH: begin
            if (rsp_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            req_ready        = 1'b1;
            cmd.accept_load  = req_valid && req_action == ACT_LOAD;
            cmd.accept_query = req_valid && req_action == ACT_QUERY;
         end
         STATE_LOCATE: begin
            cmd.issue       = !status.trivial && !status.all_issued && !status.hit_found;
            cmd.start_score = locate_done && !status.trivial && status.hit_found;
         end
         STATE_SCORE: begin
            cmd.score_mode = 1'b1;
            cmd.issue      = !status.all_issued;
         end
         STATE_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/dfs_datapath.sv]
// Datapath of the directional focus select block: target table, containment and scoring.
module dfs_datapath #(
   parameter int MAX_TARGETS = dfs_pkg::DFS_MAX_TARGETS,
   parameter int COORD_BITS  = dfs_pkg::DFS_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dfs_pkg::ctrl_cmd_type                   cmd,
   output dfs_pkg::ctrl_status_type                status,
   input  logic        [dfs_pkg::ENTRY_BITS-1:0]   req_entry_index,
   input  logic signed [COORD_BITS-1:0]            req_rect_left,
   input  logic signed [COORD_BITS-1:0]            req_rect_top,
   input  logic signed [COORD_BITS-1:0]            req_rect_right,
   input  logic signed [COORD_BITS-1:0]            req_rect_bottom,
   input  logic        [dfs_pkg::COUNT_BITS-1:0]   req_target_count,
   input  logic signed [COORD_BITS-1:0]            req_cursor_x,
   input  logic signed [COORD_BITS-1:0]            req_cursor_y,
   input  logic signed [dfs_pkg::DIR_BITS-1:0]     req_horizontal,
   input  logic signed [dfs_pkg::DIR_BITS-1:0]     req_vertical,
   output logic signed [dfs_pkg::CHOSEN_BITS-1:0]  rsp_chosen_index
);
   import dfs_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int IW   = $clog2(MAX_TARGETS);
   localparam int CNTW = $clog2(MAX_TARGETS + 1);
   localparam int EW   = 6 * CB;
   localparam int DW   = CB + 1;
   localparam int SW   = DW + ACROSS_SHIFT + 1;

   function automatic logic signed [CB-1:0] centre(input logic signed [CB-1:0] a,
                                                   input logic signed [CB-1:0] b);
      logic signed [CB:0] s;
      s = {a[CB-1], a} + {b[CB-1], b};
      // Round a negative half-sum toward zero before the shift.
      s = s + {{CB{1'b0}}, s[CB]};
      return s[CB:1];
   endfunction

   // Table write
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;

   assign wr_en   = cmd.accept_load && (32'(req_entry_index) < 32'(MAX_TARGETS));
   assign wr_addr = IW'(req_entry_index);
   assign wr_data = {req_rect_left, req_rect_top, req_rect_right, req_rect_bottom,
                     centre(req_rect_left, req_rect_right),
                     centre(req_rect_top, req_rect_bottom)};

   // Query context
   logic [CNTW-1:0]      n_ff;
   logic [CNTW-1:0]      n_in;
   logic signed [CB-1:0] qx_ff, qy_ff;
   logic                 h_nz_ff, h_neg_ff, v_nz_ff, v_neg_ff;
   logic [IW-1:0]        cur_ff;
   logic                 hit_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic [CNTW-1:0]      cnt_in;

   assign n_in = (32'(req_target_count) > 32'(MAX_TARGETS)) ? CNTW'(MAX_TARGETS)
                                                             : CNTW'(req_target_count);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.accept_query || cmd.start_score) begin
         cnt_in = '0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + CNTW'(1);
      end
   end

   dfs_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_TARGETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // Read stage
   logic                 rd_vld_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic signed [CB-1:0] e_l, e_t, e_r, e_b, e_cx, e_cy;
   logic                 contains;

   assign e_l  = rd_data[6*CB-1 -: CB];
   assign e_t  = rd_data[5*CB-1 -: CB];
   assign e_r  = rd_data[4*CB-1 -: CB];
   assign e_b  = rd_data[3*CB-1 -: CB];
   assign e_cx = rd_data[2*CB-1 -: CB];
   assign e_cy = rd_data[CB-1:0];

   assign contains = (e_l <= qx_ff) && (qx_ff < e_r) && (e_t <= qy_ff) && (qy_ff < e_b);

   logic hit_take;
   assign hit_take = rd_vld_ff && !cmd.score_mode && !hit_ff && contains;

   // Score stage
   logic signed [DW-1:0] dx, dy, along, across_src;
   logic        [DW-1:0] across;
   logic signed [SW-1:0] weighted, score;

   always_comb begin
      dx         = DW'(e_cx) - DW'(qx_ff);
      dy         = DW'(e_cy) - DW'(qy_ff);
      along      = h_nz_ff ? (h_neg_ff ? -dx : dx) : (v_neg_ff ? -dy : dy);
      across_src = h_nz_ff ? dy : dx;
      across     = across_src[DW-1] ? DW'(-across_src) : DW'(across_src);
      weighted   = signed'({1'b0, across, {ACROSS_SHIFT{1'b0}}});
      score      = SW'(along) + weighted;
   end

   logic                 sc_vld_ff;
   logic [IW-1:0]        sc_idx_ff;
   logic                 sc_self_ff, sc_pos_ff, sc_neg_ff;
   logic signed [SW-1:0] sc_score_ff;

   // Compare stage: forward and wrap candidates side by side
   logic                 fwd_found_ff, wrap_found_ff;
   logic [IW-1:0]        fwd_pick_ff, wrap_pick_ff;
   logic signed [SW-1:0] fwd_best_ff, wrap_best_ff;
   logic                 fwd_take, wrap_take;

   assign fwd_take  = sc_vld_ff && !sc_self_ff && sc_pos_ff
                      && (!fwd_found_ff || sc_score_ff < fwd_best_ff);
   assign wrap_take = sc_vld_ff && !sc_self_ff && sc_neg_ff
                      && (!wrap_found_ff || sc_score_ff < wrap_best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff     <= 1'b0;
         sc_vld_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         fwd_found_ff  <= 1'b0;
         wrap_found_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         sc_vld_ff <= rd_vld_ff && cmd.score_mode;
         if (cmd.accept_query) begin
            hit_ff <= 1'b0;
         end else if (hit_take) begin
            hit_ff <= 1'b1;
         end
         if (cmd.start_score) begin
            fwd_found_ff  <= 1'b0;
            wrap_found_ff <= 1'b0;
         end else begin
            if (fwd_take) begin
               fwd_found_ff <= 1'b1;
            end
            if (wrap_take) begin
               wrap_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (cmd.accept_query) begin
         n_ff     <= n_in;
         qx_ff    <= req_cursor_x;
         qy_ff    <= req_cursor_y;
         h_nz_ff  <= |req_horizontal;
         h_neg_ff <= req_horizontal[DIR_BITS-1];
         v_nz_ff  <= |req_vertical;
         v_neg_ff <= req_vertical[DIR_BITS-1];
      end else if (hit_take) begin
         qx_ff  <= e_cx;
         qy_ff  <= e_cy;
         cur_ff <= rd_idx_ff;
      end
      if (cmd.issue) begin
         rd_idx_ff <= cnt_ff[IW-1:0];
      end
      sc_idx_ff   <= rd_idx_ff;
      sc_self_ff  <= (rd_idx_ff == cur_ff);
      sc_pos_ff   <= !along[DW-1] && (|along);
      sc_neg_ff   <= along[DW-1];
      sc_score_ff <= score;
      if (fwd_take) begin
         fwd_best_ff <= sc_score_ff;
         fwd_pick_ff <= sc_idx_ff;
      end
      if (wrap_take) begin
         wrap_best_ff <= sc_score_ff;
         wrap_pick_ff <= sc_idx_ff;
      end
   end

   // Result selection
   logic [CNTW-1:0]        last_cnt;
   logic [IW-1:0]          sel_idx;
   logic                   trivial;
   logic [CHOSEN_BITS-1:0] rsp_in;
   logic [CHOSEN_BITS-1:0] rsp_ff;

   assign trivial  = (n_ff == '0) || (!h_nz_ff && !v_nz_ff);
   assign last_cnt = n_ff - CNTW'(1);

   always_comb begin
      priority if (!hit_ff) begin
         sel_idx = (h_neg_ff || v_neg_ff) ? last_cnt[IW-1:0] : '0;
      end else if (fwd_found_ff) begin
         sel_idx = fwd_pick_ff;
      end else if (wrap_found_ff) begin
         sel_idx = wrap_pick_ff;
      end else begin
         sel_idx = cur_ff;
      end
      rsp_in = trivial ? INVALID_INDEX : CHOSEN_BITS'(sel_idx);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chosen_index  = signed'(rsp_ff);

   assign status.trivial    = trivial;
   assign status.all_issued = (cnt_ff == n_ff);
   assign status.pipe_busy  = rd_vld_ff || sc_vld_ff;
   assign status.hit_found  = hit_ff;

endmodule

[hw/rtl/directional_focus_select.sv]
// Top level of the directional focus select block: sequencer, datapath and checks.
//
// Holds a table of MAX_TARGETS rectangles and answers directional focus queries
// over it. A load transaction writes one rectangle and returns nothing; slots
// at or beyond MAX_TARGETS are ignored. A query transaction walks the table
// through the single read port of the target RAM: a locate walk that stops at
// the first rectangle holding the cursor, then, after a hit, a scoring walk over
// slots 0 to count-1 (count capped at MAX_TARGETS) that tracks the best forward
// and the best wrap candidate side by side. A cursor outside every rectangle
// finishes after the locate walk, and a zero count or a zero step finishes
// without a walk. One query is in flight at a time; the input side takes the
// next transaction as soon as the answer sits in the output register, even if
// that answer has not yet been taken, and a following query then waits in its
// last state for as long as the receiver stalls. The table has no reset: read
// only slots that have been loaded.
`include "assert_macros.svh"

module directional_focus_select #(
   parameter int MAX_TARGETS = dfs_pkg::DFS_MAX_TARGETS,
   parameter int COORD_BITS  = dfs_pkg::DFS_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic        [dfs_pkg::ENTRY_BITS-1:0]   req_entry_index,
   input  logic signed [COORD_BITS-1:0]            req_rect_left,
   input  logic signed [COORD_BITS-1:0]            req_rect_top,
   input  logic signed [COORD_BITS-1:0]            req_rect_right,
   input  logic signed [COORD_BITS-1:0]            req_rect_bottom,
   input  logic        [dfs_pkg::COUNT_BITS-1:0]   req_target_count,
   input  logic signed [COORD_BITS-1:0]            req_cursor_x,
   input  logic signed [COORD_BITS-1:0]            req_cursor_y,
   input  logic signed [dfs_pkg::DIR_BITS-1:0]     req_horizontal,
   input  logic signed [dfs_pkg::DIR_BITS-1:0]     req_vertical,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dfs_pkg::CHOSEN_BITS-1:0]  rsp_chosen_index
);
   import dfs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequence handshakes and the two table walks.
   dfs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the table, test containment, score candidates and register the answer.
   dfs_datapath #(
      .MAX_TARGETS (MAX_TARGETS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_entry_index  (req_entry_index),
      .req_rect_left    (req_rect_left),
      .req_rect_top     (req_rect_top),
      .req_rect_right   (req_rect_right),
      .req_rect_bottom  (req_rect_bottom),
      .req_target_count (req_target_count),
      .req_cursor_x     (req_cursor_x),
      .req_cursor_y     (req_cursor_y),
      .req_horizontal   (req_horizontal),
      .req_vertical     (req_vertical),
      .rsp_chosen_index (rsp_chosen_index)
   );

   // Never read past the query's target count.
   `ASSERT_IMPLY(a_issue_in_range, clock, reset, cmd.issue, !status.all_issued)

   // Never overwrite an answer that is still waiting to be taken.
   `ASSERT_IMPLY(a_no_rsp_overrun, clock, reset, cmd.load_rsp, !rsp_valid || rsp_ready)

   // Start scoring only after a hit, with the locate pipe drained.
   `ASSERT_IMPLY(a_score_after_hit, clock, reset, cmd.start_score, status.hit_found && !status.pipe_busy)

   // An accepted query closes the input side until its answer is registered.
   `ASSERT_NEXT(a_query_blocks, clock, reset, req_valid && req_ready && req_action == ACT_QUERY, !req_ready)

endmodule
